// File: design/sfpf_pkg.sv
// Package: payload types, register indexes and format codes for the sample-to-float converter
package sfpf_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_FORMAT  = 1'b0,
    REG_SCALE_EXPONENT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FMT_INT32 = 2'd0,
    FMT_INT16 = 2'd1,
    FMT_INT8  = 2'd2,
    FMT_SPARE = 2'd3
  } sample_fmt_e;

  typedef struct packed {
    logic [31:0] raw_sample;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] float_bits;
    logic        last_out;
  } out_item_t;

  // Stage 1 -> stage 2: sign and magnitude
  typedef struct packed {
    logic        sign;
    logic [31:0] mag;
    logic        last;
  } mag_t;

  // Stage 2 -> stage 3: normalized magnitude
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic [4:0]  top;
    logic [31:0] norm;
    logic        last;
  } norm_t;

endpackage

// File: design/sfpf_unpack.sv
// Stage 1: sample width select, sign extension and magnitude
module sfpf_unpack import sfpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        vld_i,
  input  in_item_t    item_i,
  input  logic [1:0]  fmt_i,
  output logic        vld_o,
  output mag_t        data_o
);

  logic        vld_q;
  mag_t        data_q, data_d;
  logic [31:0] sx;

  // Sign-extend the selected width
  always_comb begin
    case (sample_fmt_e'(fmt_i))
      FMT_INT16: sx = {{16{item_i.raw_sample[15]}}, item_i.raw_sample[15:0]};
      FMT_INT8:  sx = {{24{item_i.raw_sample[7]}}, item_i.raw_sample[7:0]};
      default:   sx = item_i.raw_sample;
    endcase
    data_d.sign = sx[31];
    data_d.mag  = sx[31] ? (~sx + 32'd1) : sx;
    data_d.last = item_i.last_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// File: design/sfpf_norm.sv
// Stage 2: leading-one search and left normalization
module sfpf_norm import sfpf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  vld_i,
  input  mag_t  data_i,
  output logic  vld_o,
  output norm_t data_o
);

  logic  vld_q;
  norm_t data_q, data_d;
  logic [4:0] lz;

  // Priority encoder over the magnitude
  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (data_i.mag[i]) lz = 5'(31 - i);
    end
    data_d.sign = data_i.sign;
    data_d.zero = (data_i.mag == 32'd0);
    data_d.top  = 5'd31 - lz;
    data_d.norm = data_i.mag << lz;
    data_d.last = data_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// File: design/sfpf_round.sv
// Stage 3: round to nearest even, exponent bias and packing
module sfpf_round import sfpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        vld_i,
  input  norm_t       data_i,
  input  logic [5:0]  scale_i,
  output logic        vld_o,
  output out_item_t   data_o
);

  logic       vld_q;
  out_item_t  data_q, data_d;
  logic [24:0] man;
  logic        rnd_up;
  logic [8:0]  expo;

  // norm[31] is the hidden one; guard at bit 7, sticky below
  always_comb begin
    rnd_up = data_i.norm[7] & ((|data_i.norm[6:0]) | data_i.norm[8]);
    man    = {1'b0, data_i.norm[31:8]} + {24'd0, rnd_up};
    expo   = 9'd127 + {4'd0, data_i.top} - {{3{scale_i[5]}}, scale_i} + {8'd0, man[24]};
    data_d.last_out = data_i.last;
    if (data_i.zero) begin
      data_d.float_bits = 32'd0;
    end else begin
      data_d.float_bits = {data_i.sign, expo[7:0],
                           man[24] ? man[23:1] : man[22:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// File: design/scaled_fixed_point_to_float.sv
// Top level: integer trace sample to scaled IEEE-754 single converter
//
//  channel | signals                              | handshake
//  input   | in_valid_i, in_stall_o, in_item_i    | accept: valid & !stall
//  output  | out_valid_o, out_stall_i, out_item_o | accept: valid & !stall
//  config  | cfg_valid_i, cfg_ready_o, cfg_idx_i, cfg_data_i | write: valid & ready
//
// Three register stages (unpack, normalize, round) share one advance enable.
// One item per cycle is sustained; the pipeline advances whenever its last
// stage is empty or its result is taken, so a stall freezes all stages.
// Reset clears the valid bits and both registers (format 0, exponent 0).
module scaled_fixed_point_to_float import sfpf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [1:0] fmt_reg_q;
  logic [5:0] scale_q;
  logic       adv;
  logic       v1, v2, v3;
  mag_t       m1;
  norm_t      n2;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_reg_q <= 2'd0;
      scale_q   <= 6'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SAMPLE_FORMAT:  fmt_reg_q <= cfg_data_i[1:0];
        REG_SCALE_EXPONENT: scale_q   <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves together
  assign adv        = ~(v3 & out_stall_i);
  assign in_stall_o = ~adv;

  sfpf_unpack u_unpack (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(in_valid_i), .item_i(in_item_i),
    .fmt_i(fmt_reg_q), .vld_o(v1), .data_o(m1)
  );

  sfpf_norm u_norm (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(v1), .data_i(m1),
    .vld_o(v2), .data_o(n2)
  );

  sfpf_round u_round (
    .clk_i, .rst_ni, .adv_i(adv), .vld_i(v2), .data_i(n2), .scale_i(scale_q),
    .vld_o(v3), .data_o(out_item_o)
  );

  assign out_valid_o = v3;

  // A stalled result must hold
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed under stall");

  // Zero always encodes as +0
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.float_bits[30:0] == 31'd0 |-> !out_item_o.float_bits[31])
    else $error("negative zero produced");

  // Input is taken whenever the output side is free
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("pipeline blocked without a pending result");

endmodule
